[rtl/core/gasp_pkg.sv]
// ----------------------------------------------------------------------------
// gasp_pkg
// Shared constants, types and helpers of the grid A* path search block.
// ----------------------------------------------------------------------------
package gasp_pkg;

	localparam int GRID_W     = 32;
	localparam int GRID_H     = 32;
	localparam int OPEN_DEPTH = 1024;
	localparam int COST_BITS  = 16;

	localparam int XW     = $clog2(GRID_W);
	localparam int YW     = $clog2(GRID_H);
	localparam int CELL_W = XW + YW;
	localparam int CELLS  = GRID_W * GRID_H;
	localparam int CNT_W  = $clog2(CELLS) + 1;
	localparam int OAW    = $clog2(OPEN_DEPTH);
	localparam int OCW    = OAW + 1;
	localparam int STEP_W = 8;
	localparam int H_W    = XW + STEP_W;
	localparam int F_W    = COST_BITS + 1;

	localparam logic [STEP_W-1:0] STEP_RESET = 8'd10;
	localparam logic [STEP_W-1:0] DIAG_EXTRA = 8'd5;

	localparam logic [1:0] OP_WRITE  = 2'd0;
	localparam logic [1:0] OP_SEARCH = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
	localparam logic [1:0] STAT_OVERFLOW = 2'd2;
	localparam logic [1:0] STAT_RANGE    = 2'd3;

	localparam logic [1:0] FLAG_NONE   = 2'd0;
	localparam logic [1:0] FLAG_OPEN   = 2'd1;
	localparam logic [1:0] FLAG_CLOSED = 2'd2;

	// per-cell record write: one address, field enables
	typedef struct packed {
		logic                 we_blk;
		logic                 we_flag;
		logic                 we_g;
		logic                 we_dir;
		logic                 we_pos;
		logic [CELL_W-1:0]    addr;
		logic                 blk;
		logic [1:0]           flag;
		logic [COST_BITS-1:0] g;
		logic [2:0]           dir;
		logic [OAW-1:0]       pos;
	} cell_wr_t;

	typedef struct packed {
		logic                 blk;
		logic [1:0]           flag;
		logic [COST_BITS-1:0] g;
		logic [2:0]           dir;
		logic [OAW-1:0]       pos;
	} cell_rd_t;

	typedef struct packed {
		logic              ok;
		logic [CELL_W-1:0] tgt;
	} move_t;

	// direction order NW,N,NE,W,E,SW,S,SE; back steps against the direction
	function automatic move_t cell_move(input logic [CELL_W-1:0] c, input logic [2:0] d,
		input logic back);
		int    dx;
		int    dy;
		int    nx;
		int    ny;
		move_t m;
		case (d)
			3'd0: begin dx = -1; dy = -1; end
			3'd1: begin dx = 0;  dy = -1; end
			3'd2: begin dx = 1;  dy = -1; end
			3'd3: begin dx = -1; dy = 0;  end
			3'd4: begin dx = 1;  dy = 0;  end
			3'd5: begin dx = -1; dy = 1;  end
			3'd6: begin dx = 0;  dy = 1;  end
			default: begin dx = 1; dy = 1; end
		endcase
		if (back) begin
			dx = -dx;
			dy = -dy;
		end
		nx = int'(c[XW-1:0]) + dx;
		ny = int'(c[CELL_W-1:XW]) + dy;
		m.ok  = (nx >= 0) && (ny >= 0) && (nx < GRID_W) && (ny < GRID_H);
		m.tgt = {YW'(ny), XW'(nx)};
		return m;
	endfunction

	function automatic logic is_diag(input logic [2:0] d);
		return (d inside {3'd0, 3'd2, 3'd5, 3'd7});
	endfunction

	// Chebyshev distance times step cost
	function automatic logic [H_W-1:0] heur(input logic [CELL_W-1:0] c,
		input logic [CELL_W-1:0] g, input logic [STEP_W-1:0] step);
		logic [XW-1:0] dx;
		logic [YW-1:0] dy;
		logic [XW-1:0] m;
		dx = (c[XW-1:0] > g[XW-1:0]) ? c[XW-1:0] - g[XW-1:0] : g[XW-1:0] - c[XW-1:0];
		dy = (c[CELL_W-1:XW] > g[CELL_W-1:XW]) ? c[CELL_W-1:XW] - g[CELL_W-1:XW]
			: g[CELL_W-1:XW] - c[CELL_W-1:XW];
		m = (XW'(dy) > dx) ? XW'(dy) : dx;
		return H_W'(m) * H_W'(step);
	endfunction

endpackage

[rtl/core/grid_astar_path_search.sv]
// ----------------------------------------------------------------------------
// grid_astar_path_search
// A* search over an 8-connected occupancy grid with path readback.
// ----------------------------------------------------------------------------
// Usage: an item is taken when start is high and busy is low. Operation
// selects a map cell write, a search, or a path step read. Every item gives
// one result word, shown for one cycle with done high; the receiver cannot
// stall it. cfg_valid/cfg_data write the straight-move cost (cfg_ready is
// always high).
// Map writes: result in the cycle after accept, one per cycle back to back.
// Path reads: result through the S_RD state (one path RAM read).
// Search: data dependent. Endpoint check, a flag clear pass over all cells,
// then per expansion one open-list scan (full log length incl. dead
// entries) and a pop, a check of each neighbor (off-grid, skipped or
// appended), a close step, occasional log compaction, and the walk back
// over the path cells.
// The open list is an insertion-ordered log in RAM with lazy deletion.
// Reset: busy stays high during a pass that clears the map and flags; the
// move cost returns to 10 and the stored path is empty.
// ----------------------------------------------------------------------------
module grid_astar_path_search (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [4:0]  cell_x,
	input  logic [4:0]  cell_y,
	input  logic        cell_blocked,
	input  logic [4:0]  origin_x,
	input  logic [4:0]  origin_y,
	input  logic [4:0]  goal_x,
	input  logic [4:0]  goal_y,
	input  logic [9:0]  step_index,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	output logic        done,
	output logic [1:0]  status,
	output logic [10:0] path_length,
	output logic [4:0]  path_x,
	output logic [4:0]  path_y
);
	import gasp_pkg::*;

	localparam logic [4:0] S_CLR   = 5'd0;
	localparam logic [4:0] S_IDLE  = 5'd1;
	localparam logic [4:0] S_RD    = 5'd2;
	localparam logic [4:0] S_BS    = 5'd3;
	localparam logic [4:0] S_BG    = 5'd4;
	localparam logic [4:0] S_BCHK  = 5'd5;
	localparam logic [4:0] S_FCLR  = 5'd6;
	localparam logic [4:0] S_INIT  = 5'd7;
	localparam logic [4:0] S_SCAN  = 5'd8;
	localparam logic [4:0] S_POP   = 5'd9;
	localparam logic [4:0] S_NB    = 5'd10;
	localparam logic [4:0] S_NB2   = 5'd11;
	localparam logic [4:0] S_APP   = 5'd12;
	localparam logic [4:0] S_CMP   = 5'd13;
	localparam logic [4:0] S_CLOSE = 5'd14;
	localparam logic [4:0] S_WALK  = 5'd15;
	localparam logic [4:0] S_WALK2 = 5'd16;

	logic [4:0]           state_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [OCW-1:0]       wj_q;
	logic [OCW-1:0]       tail_q;
	logic [OCW-1:0]       live_q;
	logic [STEP_W-1:0]    step_q;
	logic [CELL_W-1:0]    org_q;
	logic [CELL_W-1:0]    goal_q;
	logic                 blk_s_q;
	logic                 best_ok_q;
	logic [OAW-1:0]       best_pos_q;
	logic [CELL_W-1:0]    best_cell_q;
	logic [COST_BITS-1:0] best_g_q;
	logic [F_W-1:0]       best_f_q;
	logic [2:0]           dir_q;
	logic [CELL_W-1:0]    n_q;
	logic [COST_BITS-1:0] ng_q;
	logic [CELL_W-1:0]    c_q;
	logic [CNT_W-1:0]     found_len_q;
	logic                 done_q;
	logic [1:0]           status_q;
	logic [4:0]           px_q;
	logic [4:0]           py_q;

	logic                 v_s1;
	logic [OAW-1:0]       pos_s1;
	logic                 v_s2;
	logic [OAW-1:0]       pos_s2;
	logic [CELL_W-1:0]    cell_s2;
	logic [H_W-1:0]       h_s2;

	// memories
	logic [CELL_W-1:0] cr_addr;
	cell_wr_t          cw;
	cell_rd_t          cr;
	logic              ol_we;
	logic [OAW-1:0]    ol_waddr;
	logic [OCW-1:0]    ol_wdata;
	logic [OAW-1:0]    ol_raddr;
	logic [OCW-1:0]    ol_rdata;
	logic              ps_we;
	logic [CELL_W-1:0] ps_raddr;
	logic [CELL_W-1:0] ps_rdata;

	gasp_cell_mem u_cell (
		.clk   (clk),
		.raddr (cr_addr),
		.cw    (cw),
		.rd    (cr)
	);

	gasp_ram #(.DEPTH(OPEN_DEPTH), .WIDTH(OCW)) u_open (
		.clk   (clk),
		.we    (ol_we),
		.waddr (ol_waddr),
		.wdata (ol_wdata),
		.raddr (ol_raddr),
		.rdata (ol_rdata)
	);

	gasp_ram #(.DEPTH(CELLS), .WIDTH(CELL_W)) u_path (
		.clk   (clk),
		.we    (ps_we),
		.waddr (cnt_q[CELL_W-1:0]),
		.wdata (c_q),
		.raddr (ps_raddr),
		.rdata (ps_rdata)
	);

	logic                 accept;
	logic                 issue;
	logic [CELL_W-1:0]    ol_cell;
	logic                 ol_valid;
	move_t                mv_nb;
	move_t                mv_back;
	logic [8:0]           step_c;
	logic [F_W-1:0]       sum_c;
	logic [COST_BITS-1:0] ng_c;
	logic                 skip_c;
	logic [OCW-1:0]       live_eff;
	logic [F_W-1:0]       f_c;
	logic [CNT_W-1:0]     rd_idx;

	assign accept    = start && !busy;
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign done        = done_q;
	assign status      = status_q;
	assign path_length = found_len_q;
	assign path_x      = px_q;
	assign path_y      = py_q;

	assign issue    = (cnt_q < CNT_W'(tail_q));
	assign ol_cell  = ol_rdata[CELL_W-1:0];
	assign ol_valid = ol_rdata[OCW-1];
	assign mv_nb    = cell_move(best_cell_q, dir_q, 1'b0);
	assign mv_back  = cell_move(c_q, cr.dir, 1'b1);
	assign step_c   = {1'b0, step_q} + (is_diag(dir_q) ? {1'b0, DIAG_EXTRA} : 9'd0);
	assign sum_c    = {1'b0, best_g_q} + F_W'(step_c);
	assign ng_c     = sum_c[F_W-1] ? {COST_BITS{1'b1}} : sum_c[COST_BITS-1:0];
	assign skip_c   = cr.blk || ((cr.flag != FLAG_NONE) && (cr.g <= ng_c));
	assign live_eff = (cr.flag == FLAG_OPEN) ? live_q - 1'b1 : live_q;
	assign f_c      = {1'b0, cr.g} + F_W'(h_s2);
	assign rd_idx   = found_len_q - CNT_W'(1) - CNT_W'(step_index);
	assign ps_raddr = rd_idx[CELL_W-1:0];
	assign ol_raddr = cnt_q[OAW-1:0];
	assign ps_we    = (state_q == S_WALK) && (cnt_q != CNT_W'(CELLS));

	always_comb begin
		case (state_q)
			S_BS:    cr_addr = org_q;
			S_BG:    cr_addr = goal_q;
			S_SCAN:  cr_addr = ol_cell;
			S_NB:    cr_addr = mv_nb.tgt;
			S_WALK:  cr_addr = c_q;
			default: cr_addr = '0;
		endcase
	end

	always_comb begin
		cw = '0;
		ol_we    = 1'b0;
		ol_waddr = '0;
		ol_wdata = '0;
		case (state_q)
			S_CLR: begin
				cw.we_blk  = 1'b1;
				cw.we_flag = 1'b1;
				cw.addr    = cnt_q[CELL_W-1:0];
				cw.flag    = FLAG_NONE;
			end
			S_IDLE: begin
				cw.we_blk = accept && (operation == OP_WRITE);
				cw.addr   = {cell_y, cell_x};
				cw.blk    = cell_blocked;
			end
			S_FCLR: begin
				cw.we_flag = 1'b1;
				cw.addr    = cnt_q[CELL_W-1:0];
				cw.flag    = FLAG_NONE;
			end
			S_INIT: begin
				cw.we_flag = 1'b1;
				cw.we_g    = 1'b1;
				cw.we_pos  = 1'b1;
				cw.addr    = org_q;
				cw.flag    = FLAG_OPEN;
				ol_we      = 1'b1;
				ol_wdata   = {1'b1, org_q};
			end
			S_POP: begin
				ol_we    = 1'b1;
				ol_waddr = best_pos_q;
				ol_wdata = {1'b0, best_cell_q};
			end
			S_NB2: begin
				// drop the stale list entry of an improved open cell
				ol_we    = !skip_c && (cr.flag == FLAG_OPEN);
				ol_waddr = cr.pos;
				ol_wdata = {1'b0, n_q};
			end
			S_APP: begin
				if (tail_q != OCW'(OPEN_DEPTH)) begin
					cw.we_flag = 1'b1;
					cw.we_g    = 1'b1;
					cw.we_dir  = 1'b1;
					cw.we_pos  = 1'b1;
					cw.addr    = n_q;
					cw.flag    = FLAG_OPEN;
					cw.g       = ng_q;
					cw.dir     = dir_q;
					cw.pos     = tail_q[OAW-1:0];
					ol_we      = 1'b1;
					ol_waddr   = tail_q[OAW-1:0];
					ol_wdata   = {1'b1, n_q};
				end
			end
			S_CMP: begin
				if (v_s1 && ol_valid) begin
					cw.we_pos = 1'b1;
					cw.addr   = ol_cell;
					cw.pos    = wj_q[OAW-1:0];
					ol_we     = 1'b1;
					ol_waddr  = wj_q[OAW-1:0];
					ol_wdata  = ol_rdata;
				end
			end
			S_CLOSE: begin
				cw.we_flag = 1'b1;
				cw.addr    = best_cell_q;
				cw.flag    = FLAG_CLOSED;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			step_q <= cfg_data;
		end
	end

	// scan / compaction read pipeline
	always_ff @(posedge clk) begin
		pos_s1  <= cnt_q[OAW-1:0];
		pos_s2  <= pos_s1;
		cell_s2 <= ol_cell;
		h_s2    <= heur(ol_cell, goal_q, step_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			cnt_q       <= '0;
			wj_q        <= '0;
			tail_q      <= '0;
			live_q      <= '0;
			found_len_q <= '0;
			done_q      <= 1'b0;
			status_q    <= STAT_OK;
			px_q        <= '0;
			py_q        <= '0;
			best_ok_q   <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			dir_q       <= '0;
		end else begin
			done_q <= 1'b0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			case (state_q)
				S_CLR: begin
					if (cnt_q == CNT_W'(CELLS - 1)) begin
						state_q <= S_IDLE;
					end
					cnt_q <= cnt_q + 1'b1;
				end
				S_IDLE: begin
					if (accept) begin
						px_q     <= '0;
						py_q     <= '0;
						status_q <= STAT_OK;
						case (operation)
							OP_SEARCH: begin
								org_q       <= {origin_y, origin_x};
								goal_q      <= {goal_y, goal_x};
								found_len_q <= '0;
								state_q     <= S_BS;
							end
							OP_READ: begin
								if (CNT_W'(step_index) < found_len_q) begin
									state_q <= S_RD;
								end else begin
									status_q <= STAT_RANGE;
									done_q   <= 1'b1;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_RD: begin
					px_q    <= ps_rdata[XW-1:0];
					py_q    <= ps_rdata[CELL_W-1:XW];
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_BS: state_q <= S_BG;
				S_BG: begin
					blk_s_q <= cr.blk;
					state_q <= S_BCHK;
				end
				S_BCHK: begin
					if (blk_s_q || cr.blk) begin
						status_q <= STAT_NOT_FOUND;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						cnt_q   <= '0;
						state_q <= S_FCLR;
					end
				end
				S_FCLR: begin
					if (cnt_q == CNT_W'(CELLS - 1)) begin
						state_q <= S_INIT;
					end
					cnt_q <= cnt_q + 1'b1;
				end
				S_INIT: begin
					tail_q    <= OCW'(1);
					live_q    <= OCW'(1);
					cnt_q     <= '0;
					best_ok_q <= 1'b0;
					state_q   <= S_SCAN;
				end
				S_SCAN: begin
					if (live_q == '0) begin
						status_q <= STAT_NOT_FOUND;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						if (issue) begin
							cnt_q <= cnt_q + 1'b1;
						end
						v_s1 <= issue;
						v_s2 <= v_s1 && ol_valid;
						// first lowest f wins: strict compare in log order
						if (v_s2 && (!best_ok_q || f_c < best_f_q)) begin
							best_ok_q   <= 1'b1;
							best_f_q    <= f_c;
							best_g_q    <= cr.g;
							best_pos_q  <= pos_s2;
							best_cell_q <= cell_s2;
						end
						if (!issue && !v_s1 && !v_s2) begin
							state_q <= S_POP;
						end
					end
				end
				S_POP: begin
					live_q <= live_q - 1'b1;
					dir_q  <= '0;
					if (best_cell_q == goal_q) begin
						cnt_q   <= '0;
						c_q     <= goal_q;
						state_q <= S_WALK;
					end else begin
						state_q <= S_NB;
					end
				end
				S_NB: begin
					if (mv_nb.ok) begin
						n_q     <= mv_nb.tgt;
						state_q <= S_NB2;
					end else if (dir_q == 3'd7) begin
						state_q <= S_CLOSE;
					end else begin
						dir_q <= dir_q + 1'b1;
					end
				end
				S_NB2: begin
					if (skip_c) begin
						if (dir_q == 3'd7) begin
							state_q <= S_CLOSE;
						end else begin
							dir_q   <= dir_q + 1'b1;
							state_q <= S_NB;
						end
					end else if (live_eff >= OCW'(OPEN_DEPTH)) begin
						found_len_q <= '0;
						status_q    <= STAT_OVERFLOW;
						done_q      <= 1'b1;
						state_q     <= S_IDLE;
					end else begin
						live_q  <= live_eff;
						ng_q    <= ng_c;
						state_q <= S_APP;
					end
				end
				S_APP: begin
					if (tail_q == OCW'(OPEN_DEPTH)) begin
						cnt_q   <= '0;
						wj_q    <= '0;
						state_q <= S_CMP;
					end else begin
						tail_q <= tail_q + 1'b1;
						live_q <= live_q + 1'b1;
						if (dir_q == 3'd7) begin
							state_q <= S_CLOSE;
						end else begin
							dir_q   <= dir_q + 1'b1;
							state_q <= S_NB;
						end
					end
				end
				S_CMP: begin
					if (issue) begin
						cnt_q <= cnt_q + 1'b1;
					end
					v_s1 <= issue;
					if (v_s1 && ol_valid) begin
						wj_q <= wj_q + 1'b1;
					end
					if (!issue && !v_s1) begin
						tail_q  <= wj_q;
						state_q <= S_APP;
					end
				end
				S_CLOSE: begin
					cnt_q     <= '0;
					best_ok_q <= 1'b0;
					state_q   <= S_SCAN;
				end
				S_WALK: begin
					if (cnt_q == CNT_W'(CELLS)) begin
						status_q <= STAT_NOT_FOUND;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
						if (c_q == org_q) begin
							found_len_q <= cnt_q + 1'b1;
							status_q    <= STAT_OK;
							done_q      <= 1'b1;
							state_q     <= S_IDLE;
						end else begin
							state_q <= S_WALK2;
						end
					end
				end
				S_WALK2: begin
					if (mv_back.ok) begin
						c_q     <= mv_back.tgt;
						state_q <= S_WALK;
					end else begin
						status_q <= STAT_NOT_FOUND;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_live_le_tail: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= tail_q)
		else $error("open list live count above log length");

	a_tail_depth: assert property (@(posedge clk) disable iff (!arst_n)
		tail_q <= OCW'(OPEN_DEPTH))
		else $error("open list log past depth");

	a_write_done: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (operation == OP_WRITE)) |=> (done && (status == STAT_OK)))
		else $error("map write word not returned next cycle");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy || $past(state_q == S_IDLE))
		else $error("result word outside of idle return");

endmodule

[rtl/core/gasp_ram.sv]
// ----------------------------------------------------------------------------
// gasp_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module gasp_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 10
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/gasp_cell_mem.sv]
// ----------------------------------------------------------------------------
// gasp_cell_mem
// Per-cell records: occupancy, open/closed flags, cost, back direction and
// open-list position. One read and one field-masked write per cycle.
// ----------------------------------------------------------------------------
module gasp_cell_mem (
	input  logic                            clk,
	input  logic [gasp_pkg::CELL_W-1:0]     raddr,
	input  gasp_pkg::cell_wr_t              cw,
	output gasp_pkg::cell_rd_t              rd
);
	import gasp_pkg::*;

	logic                 blk_mem  [CELLS];
	logic [1:0]           flag_mem [CELLS];
	logic [COST_BITS-1:0] g_mem    [CELLS];
	logic [2:0]           dir_mem  [CELLS];
	logic [OAW-1:0]       pos_mem  [CELLS];

	always_ff @(posedge clk) begin
		if (cw.we_blk)  blk_mem[cw.addr]  <= cw.blk;
		if (cw.we_flag) flag_mem[cw.addr] <= cw.flag;
		if (cw.we_g)    g_mem[cw.addr]    <= cw.g;
		if (cw.we_dir)  dir_mem[cw.addr]  <= cw.dir;
		if (cw.we_pos)  pos_mem[cw.addr]  <= cw.pos;
		rd.blk  <= blk_mem[raddr];
		rd.flag <= flag_mem[raddr];
		rd.g    <= g_mem[raddr];
		rd.dir  <= dir_mem[raddr];
		rd.pos  <= pos_mem[raddr];
	end

endmodule

[dv/grid_astar_path_search_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_astar_path_search_checker
// Watches the command, config and result channels of the grid A* block,
// keeps its own copy of map, step cost and stored path, predicts each result
// word and compares it field by field against what the block returns.
// ----------------------------------------------------------------------------
module grid_astar_path_search_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  operation,
	input  logic [4:0]  cell_x,
	input  logic [4:0]  cell_y,
	input  logic        cell_blocked,
	input  logic [4:0]  origin_x,
	input  logic [4:0]  origin_y,
	input  logic [4:0]  goal_x,
	input  logic [4:0]  goal_y,
	input  logic [9:0]  step_index,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	input  logic        done,
	input  logic [1:0]  status,
	input  logic [10:0] path_length,
	input  logic [4:0]  path_x,
	input  logic [4:0]  path_y,
	output int          fail_count,
	output int          pending
);
	import gasp_pkg::*;

	typedef struct {
		logic [1:0]  st;
		logic [10:0] len;
		logic [4:0]  x;
		logic [4:0]  y;
	} reply_t;

	localparam int G_SAT = (1 << COST_BITS) - 1;

	int nb_dx[8] = '{-1, 0, 1, -1, 1, -1, 0, 1};
	int nb_dy[8] = '{-1, -1, -1, 0, 0, 1, 1, 1};

	reply_t     reply_q[$];
	logic [7:0] cost_reg;
	bit         wall[CELLS];
	int         g_val[CELLS];
	int         from_dir[CELLS];
	logic [1:0] mark[CELLS];
	int         frontier[$];
	int         route[$];

	reply_t     want;
	int         spot;

	assign pending = reply_q.size();

	function automatic int dist_cost(input int c, input int gx, input int gy);
		int dx;
		int dy;
		dx = (c % GRID_W) - gx;
		dy = (c / GRID_W) - gy;
		if (dx < 0) dx = -dx;
		if (dy < 0) dy = -dy;
		return ((dx > dy) ? dx : dy) * cost_reg;
	endfunction

	task automatic find_route(input int ox, input int oy, input int gx, input int gy,
		output logic [1:0] st);
		int src;
		int dst;
		int pick;
		int cur;
		int nx;
		int ny;
		int n;
		int ng;
		int best;
		int f;
		int c;
		bit hit;
		route.delete();
		st  = STAT_NOT_FOUND;
		src = oy * GRID_W + ox;
		dst = gy * GRID_W + gx;
		if (wall[src] || wall[dst])
			return;
		for (int k = 0; k < CELLS; k++)
			mark[k] = FLAG_NONE;
		frontier.delete();
		frontier.insert(frontier.size(), src);
		g_val[src] = 0;
		mark[src]  = FLAG_OPEN;
		hit = 0;
		while (frontier.size() > 0) begin
			pick = 0;
			best = g_val[frontier[0]] + dist_cost(frontier[0], gx, gy);
			for (int k = 1; k < frontier.size(); k++) begin
				f = g_val[frontier[k]] + dist_cost(frontier[k], gx, gy);
				if (f < best) begin
					best = f;
					pick = k;
				end
			end
			cur = frontier[pick];
			frontier.delete(pick);
			mark[cur] = FLAG_NONE;
			if (cur == dst) begin
				hit = 1;
				break;
			end
			for (int d = 0; d < 8; d++) begin
				nx = cur % GRID_W + nb_dx[d];
				ny = cur / GRID_W + nb_dy[d];
				if (nx < 0 || ny < 0 || nx >= GRID_W || ny >= GRID_H)
					continue;
				n = ny * GRID_W + nx;
				if (wall[n])
					continue;
				ng = g_val[cur] + cost_reg + ((nb_dx[d] != 0 && nb_dy[d] != 0) ? 5 : 0);
				if (ng > G_SAT)
					ng = G_SAT;
				if (mark[n] != FLAG_NONE && g_val[n] <= ng)
					continue;
				// improved open cell moves to the back of the list
				if (mark[n] == FLAG_OPEN) begin
					for (int k = 0; k < frontier.size(); k++) begin
						if (frontier[k] == n) begin
							frontier.delete(k);
							break;
						end
					end
				end
				if (frontier.size() >= OPEN_DEPTH) begin
					st = STAT_OVERFLOW;
					return;
				end
				mark[n]     = FLAG_OPEN;
				g_val[n]    = ng;
				from_dir[n] = d;
				frontier.insert(frontier.size(), n);
			end
			mark[cur] = FLAG_CLOSED;
		end
		if (!hit)
			return;
		c = dst;
		forever begin
			if (route.size() >= CELLS) begin
				route.delete();
				return;
			end
			route.push_front(c);
			if (c == src)
				break;
			nx = c % GRID_W - nb_dx[from_dir[c]];
			ny = c / GRID_W - nb_dy[from_dir[c]];
			if (nx < 0 || ny < 0 || nx >= GRID_W || ny >= GRID_H) begin
				route.delete();
				return;
			end
			c = ny * GRID_W + nx;
		end
		st = STAT_OK;
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			cost_reg   = STEP_RESET;
			fail_count = 0;
			reply_q.delete();
			route.delete();
			for (int k = 0; k < CELLS; k++)
				wall[k] = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				cost_reg = cfg_data;
			if (done) begin
				if (reply_q.size() == 0) begin
					$error("result word with nothing expected");
					fail_count++;
				end else begin
					want = reply_q.pop_front();
					if (status !== want.st) begin
						$error("status: expected %0d, actual %0d", want.st, status);
						fail_count++;
					end
					if (path_length !== want.len) begin
						$error("path_length: expected %0d, actual %0d", want.len, path_length);
						fail_count++;
					end
					if (path_x !== want.x) begin
						$error("path_x: expected %0d, actual %0d", want.x, path_x);
						fail_count++;
					end
					if (path_y !== want.y) begin
						$error("path_y: expected %0d, actual %0d", want.y, path_y);
						fail_count++;
					end
				end
			end
			if (start && !busy) begin
				want.st = STAT_OK;
				want.x  = '0;
				want.y  = '0;
				case (operation)
					OP_WRITE:  wall[cell_y * GRID_W + cell_x] = cell_blocked;
					OP_SEARCH: find_route(origin_x, origin_y, goal_x, goal_y, want.st);
					OP_READ: begin
						if (step_index < route.size()) begin
							spot   = route[step_index];
							want.x = 5'(spot % GRID_W);
							want.y = 5'(spot / GRID_W);
						end else begin
							want.st = STAT_RANGE;
						end
					end
					default: ;
				endcase
				want.len = 11'(route.size());
				reply_q.insert(reply_q.size(), want);
			end
		end
	end

endmodule

[dv/grid_astar_path_search_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_astar_path_search_test
// Drives map writes, searches, path reads and spare-op words into the grid A*
// block under several step costs and sender gap rates; a side checker predicts results.
// ----------------------------------------------------------------------------
module grid_astar_path_search_test;
	import gasp_pkg::*;

	localparam logic [1:0] OP_SPARE = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  operation;
	logic [4:0]  cell_x;
	logic [4:0]  cell_y;
	logic        cell_blocked;
	logic [4:0]  origin_x;
	logic [4:0]  origin_y;
	logic [4:0]  goal_x;
	logic [4:0]  goal_y;
	logic [9:0]  step_index;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_data;
	logic        done;
	logic [1:0]  status;
	logic [10:0] path_length;
	logic [4:0]  path_x;
	logic [4:0]  path_y;
	int          fail_count;
	int          pending;

	int gap_pct;
	int n_word[4];

	grid_astar_path_search u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .cell_x(cell_x), .cell_y(cell_y),
		.cell_blocked(cell_blocked), .origin_x(origin_x), .origin_y(origin_y),
		.goal_x(goal_x), .goal_y(goal_y), .step_index(step_index),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.done(done), .status(status), .path_length(path_length),
		.path_x(path_x), .path_y(path_y)
	);

	grid_astar_path_search_checker u_check (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .cell_x(cell_x), .cell_y(cell_y),
		.cell_blocked(cell_blocked), .origin_x(origin_x), .origin_y(origin_y),
		.goal_x(goal_x), .goal_y(goal_y), .step_index(step_index),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.done(done), .status(status), .path_length(path_length),
		.path_x(path_x), .path_y(path_y),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// one word; random gap cycles in front, returns on the accepting edge
	task automatic issue(input logic [1:0] op, input int x, input int y, input int b,
		input int ox, input int oy, input int gx, input int gy, input int idx);
		while ($urandom_range(99) < gap_pct) begin
			start <= 0;
			@(posedge clk);
		end
		start        <= 1;
		operation    <= op;
		cell_x       <= 5'(x);
		cell_y       <= 5'(y);
		cell_blocked <= b[0];
		origin_x     <= 5'(ox);
		origin_y     <= 5'(oy);
		goal_x       <= 5'(gx);
		goal_y       <= 5'(gy);
		step_index   <= 10'(idx);
		n_word[op]++;
		do @(posedge clk); while (busy);
	endtask

	task automatic drain;
		start <= 0;
		repeat (2) @(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_cost(input int v);
		cfg_data  <= 8'(v);
		cfg_valid <= 1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
	endtask

	function automatic int near(input int v);
		int r;
		r = v + $urandom_range(8) - 4;
		return (r < 0) ? 0 : (r > 31) ? 31 : r;
	endfunction

	task automatic rand_item;
		int r;
		int ox;
		int oy;
		r  = $urandom_range(99);
		ox = $urandom_range(31);
		oy = $urandom_range(31);
		if (r < 45)
			issue(OP_WRITE, $urandom_range(31), $urandom_range(31),
				$urandom_range(99) < 20, ox, oy, $urandom, $urandom, $urandom);
		else if (r < 60) begin
			// mostly short hops; a few long ones go to any cell of the map
			if ($urandom_range(99) < 4)
				issue(OP_SEARCH, $urandom, $urandom, $urandom, ox, oy,
					$urandom_range(31), $urandom_range(31), $urandom);
			else
				issue(OP_SEARCH, $urandom, $urandom, $urandom, ox, oy,
					near(ox), near(oy), $urandom);
		end else if (r < 97)
			issue(OP_READ, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom,
				($urandom_range(99) < 70) ? $urandom_range(40) : $urandom_range(1023));
		else
			issue(OP_SPARE, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom);
	endtask

	initial begin
		int costs[4];
		int gaps[4];
		arst_n       = 0;
		start        = 0;
		operation    = OP_WRITE;
		cell_x       = 0;
		cell_y       = 0;
		cell_blocked = 0;
		origin_x     = 0;
		origin_y     = 0;
		goal_x       = 0;
		goal_y       = 0;
		step_index   = 0;
		cfg_valid    = 0;
		cfg_data     = 0;
		gap_pct      = 0;
		costs = '{1, 255, $urandom_range(2, 254), 10};
		gaps  = '{0, 73, 7, 0};
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty path, spare op, trivial and corner-to-corner paths
		issue(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0);
		issue(OP_SPARE, 31, 31, 1, 31, 31, 31, 31, 1023);
		issue(OP_SEARCH, 0, 0, 0, 5, 5, 5, 5, 0);
		issue(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0);
		issue(OP_READ, 0, 0, 0, 0, 0, 0, 0, 1);
		issue(OP_SEARCH, 0, 0, 0, 0, 0, 31, 31, 0);
		issue(OP_READ, 0, 0, 0, 0, 0, 0, 0, 31);
		issue(OP_READ, 0, 0, 0, 0, 0, 0, 0, 32);
		issue(OP_READ, 0, 0, 0, 0, 0, 0, 0, 1023);
		// blocked goal clears the stored path
		issue(OP_WRITE, 31, 31, 1, 0, 0, 0, 0, 0);
		issue(OP_SEARCH, 0, 0, 0, 0, 0, 31, 31, 0);
		issue(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0);
		issue(OP_WRITE, 31, 31, 0, 0, 0, 0, 0, 0);
		issue(OP_WRITE, 0, 31, 1, 0, 0, 0, 0, 0);
		issue(OP_SEARCH, 0, 0, 0, 0, 31, 1, 31, 0);
		// walled-in goal: open list runs dry
		for (int dy = -1; dy <= 1; dy++)
			for (int dx = -1; dx <= 1; dx++)
				if (dx != 0 || dy != 0)
					issue(OP_WRITE, 20 + dx, 20 + dy, 1, 0, 0, 0, 0, 0);
		issue(OP_SEARCH, 0, 0, 0, 0, 0, 20, 20, 0);
		issue(OP_SEARCH, 0, 0, 0, 19, 22, 22, 18, 0);
		issue(OP_READ, 0, 0, 0, 0, 0, 0, 0, 2);

		for (int ph = 0; ph < 4; ph++) begin
			drain();
			write_cost(costs[ph]);
			gap_pct = gaps[ph];
			for (int i = 0; i < 440; i++)
				rand_item();
		end
		drain();

		$display("run covered %0d writes, %0d searches, %0d reads, %0d spare-op words",
			n_word[OP_WRITE], n_word[OP_SEARCH], n_word[OP_READ], n_word[OP_SPARE]);
		$display("step costs 10, 1, 255, %0d, 10; sender gap rates 0, 73, 7, 0 pct", costs[2]);
		if (fail_count == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#2000000000;
		$display("status: fail");
		$finish;
	end

endmodule

[sim.f]
rtl/core/gasp_pkg.sv
rtl/core/gasp_ram.sv
rtl/core/gasp_cell_mem.sv
rtl/core/grid_astar_path_search.sv
dv/grid_astar_path_search_checker.sv
dv/grid_astar_path_search_test.sv
